// ===== rtl/core/rgba_overlay_alpha_blend_top_macros.svh =====
// Assertion macros shared by the overlay blender RTL.
`ifndef RGBA_OVERLAY_ALPHA_BLEND_TOP_MACROS_SVH
`define RGBA_OVERLAY_ALPHA_BLEND_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ROVL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ROVL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rovl_pkg.sv =====
// Shared types, constants and helpers of the overlay blender.
package rovl_pkg;

	localparam int MAX_OVERLAY_WIDTH_DEF  = 128;
	localparam int MAX_OVERLAY_HEIGHT_DEF = 128;
	localparam int MAX_FRAME_DIM_DEF      = 4096;

	localparam int CMD_Q_DEPTH = 4;
	localparam int OUT_Q_DEPTH = 4;

	localparam int FDIM_W     = 13;
	localparam int OFS_W      = 12;
	localparam int ODIM_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int CHAN_W     = 8;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH    = 3'd0,
		REG_FRAME_HEIGHT   = 3'd1,
		REG_OVERLAY_X      = 3'd2,
		REG_OVERLAY_Y      = 3'd3,
		REG_OVERLAY_WIDTH  = 3'd4,
		REG_OVERLAY_HEIGHT = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic              is_frame;
		logic              in_window;
		logic              frame_end;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} q_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              blended;
		logic              frame_end;
	} out_item_t;

	// Bits needed to index depth entries, at least one.
	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ===== rtl/core/rgba_overlay_alpha_blend_top.sv =====
// Top level of the RGBA overlay alpha blender.
// Frame path: front stage, command queue, store read, blend stage, result queue.
// Throughput: one item per cycle, load or frame, when neither queue nor credit stalls.
// Load items produce no result; frame items produce exactly one, in order.
// Reset (arst_n low, asynchronous): counters, load address and queues clear,
// registers return to 640x480 frame, zero offset, empty overlay; the store is not cleared.
module rgba_overlay_alpha_blend_top #(
	parameter int MAX_OVERLAY_WIDTH  = rovl_pkg::MAX_OVERLAY_WIDTH_DEF,
	parameter int MAX_OVERLAY_HEIGHT = rovl_pkg::MAX_OVERLAY_HEIGHT_DEF,
	parameter int MAX_FRAME_DIM      = rovl_pkg::MAX_FRAME_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rovl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rovl_pkg::CFG_DATA_W-1:0] cfg_data,
	// input queue side
	input  logic                            push,
	output logic                            full,
	input  logic                            cmd,
	input  logic                            first,
	input  logic [rovl_pkg::CHAN_W-1:0]     red,
	input  logic [rovl_pkg::CHAN_W-1:0]     green,
	input  logic [rovl_pkg::CHAN_W-1:0]     blue,
	input  logic [rovl_pkg::CHAN_W-1:0]     alpha,
	// result queue side
	output logic                            empty,
	input  logic                            pop,
	output logic [rovl_pkg::CHAN_W-1:0]     out_red,
	output logic [rovl_pkg::CHAN_W-1:0]     out_green,
	output logic [rovl_pkg::CHAN_W-1:0]     out_blue,
	output logic                            blended,
	output logic                            frame_end
);

	localparam int DEPTH = MAX_OVERLAY_WIDTH * MAX_OVERLAY_HEIGHT;
	localparam int AW    = rovl_pkg::addr_bits(DEPTH);
	localparam int QW    = AW + $bits(rovl_pkg::q_item_t);
	localparam int OW    = $bits(rovl_pkg::out_item_t);
	localparam int CQCW  = $clog2(rovl_pkg::CMD_Q_DEPTH+1);
	localparam int OQCW  = $clog2(rovl_pkg::OUT_Q_DEPTH+1);

	// front to command queue
	logic              fq_push;
	logic [AW-1:0]     fq_addr;
	rovl_pkg::q_item_t fq_item;
	logic              fq_full;

	// command queue to back
	logic [QW-1:0]     cq_rdata;
	logic              cq_empty;
	logic              cq_pop;
	logic [CQCW-1:0]   cq_count;
	logic [AW-1:0]     bk_addr;
	rovl_pkg::q_item_t bk_item;

	// back to result queue
	logic                oq_push;
	rovl_pkg::out_item_t oq_item;
	logic                oq_full;
	logic [OQCW-1:0]     oq_count;
	logic [OW-1:0]       oq_rdata;
	rovl_pkg::out_item_t head;

	// Front: take items, track the raster, classify and compute store addresses.
	rovl_front #(
		.MAX_OW(MAX_OVERLAY_WIDTH),
		.MAX_OH(MAX_OVERLAY_HEIGHT),
		.MAX_FD(MAX_FRAME_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.first     (first),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.q_push    (fq_push),
		.q_addr    (fq_addr),
		.q_item    (fq_item),
		.q_full    (fq_full)
	);

	// Decouple front and back: loads and frame reads stay in order through here,
	// so a store write always lands before any later read of it.
	rovl_queue #(
		.WIDTH(QW),
		.DEPTH(rovl_pkg::CMD_Q_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  ({fq_addr, fq_item}),
		.full   (fq_full),
		.pop    (cq_pop),
		.rdata  (cq_rdata),
		.empty  (cq_empty),
		.count  (cq_count)
	);

	assign bk_addr = cq_rdata[QW-1:QW-AW];
	assign bk_item = rovl_pkg::q_item_t'(cq_rdata[QW-AW-1:0]);

	// Back: write or read the overlay store, then blend.
	rovl_back #(
		.DEPTH(DEPTH),
		.OUT_DEPTH(rovl_pkg::OUT_Q_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_empty  (cq_empty),
		.in_addr   (bk_addr),
		.in_item   (bk_item),
		.in_pop    (cq_pop),
		.out_full  (oq_full),
		.out_count (oq_count),
		.out_push  (oq_push),
		.out_item  (oq_item)
	);

	// Hold finished results here so the pipeline keeps moving while the consumer stalls.
	rovl_queue #(
		.WIDTH(OW),
		.DEPTH(rovl_pkg::OUT_Q_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.wdata  (oq_item),
		.full   (oq_full),
		.pop    (pop),
		.rdata  (oq_rdata),
		.empty  (empty),
		.count  (oq_count)
	);

	assign head      = rovl_pkg::out_item_t'(oq_rdata);
	assign out_red   = head.red;
	assign out_green = head.green;
	assign out_blue  = head.blue;
	assign blended   = head.blended;
	assign frame_end = head.frame_end;

endmodule

// ===== rtl/core/rovl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rovl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [rovl_pkg::addr_bits(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [rovl_pkg::addr_bits(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/rovl_queue.sv =====
// Small register FIFO with occupancy count.
module rovl_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	output logic                           full,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int PW   = rovl_pkg::addr_bits(DEPTH);
	localparam int CNTW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/core/rovl_front.sv =====
// Front end: configuration registers, raster tracking and item classification.
`include "rgba_overlay_alpha_blend_top_macros.svh"

module rovl_front #(
	parameter int MAX_OW = rovl_pkg::MAX_OVERLAY_WIDTH_DEF,
	parameter int MAX_OH = rovl_pkg::MAX_OVERLAY_HEIGHT_DEF,
	parameter int MAX_FD = rovl_pkg::MAX_FRAME_DIM_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [rovl_pkg::CFG_IDX_W-1:0]                cfg_index,
	input  logic [rovl_pkg::CFG_DATA_W-1:0]               cfg_data,
	input  logic                                          push,
	output logic                                          full,
	input  logic                                          cmd,
	input  logic                                          first,
	input  logic [rovl_pkg::CHAN_W-1:0]                   red,
	input  logic [rovl_pkg::CHAN_W-1:0]                   green,
	input  logic [rovl_pkg::CHAN_W-1:0]                   blue,
	input  logic [rovl_pkg::CHAN_W-1:0]                   alpha,
	output logic                                          q_push,
	output logic [rovl_pkg::addr_bits(MAX_OW*MAX_OH)-1:0] q_addr,
	output rovl_pkg::q_item_t                             q_item,
	input  logic                                          q_full
);

	localparam int DEPTH = MAX_OW * MAX_OH;
	localparam int AW    = rovl_pkg::addr_bits(DEPTH);
	localparam int CNT_W = rovl_pkg::addr_bits(MAX_FD);
	localparam int CW    = (CNT_W + 1 > rovl_pkg::OFS_W + 1) ? CNT_W + 1 : rovl_pkg::OFS_W + 1;
	localparam int OXW   = rovl_pkg::addr_bits(MAX_OW);
	localparam int OYW   = rovl_pkg::addr_bits(MAX_OH);
	localparam int OWM   = $clog2(MAX_OW + 1);
	localparam int PW    = OYW + OWM;

	logic [rovl_pkg::FDIM_W-1:0] frame_width_q;
	logic [rovl_pkg::FDIM_W-1:0] frame_height_q;
	logic [rovl_pkg::OFS_W-1:0]  overlay_x_q;
	logic [rovl_pkg::OFS_W-1:0]  overlay_y_q;
	logic [rovl_pkg::ODIM_W-1:0] overlay_width_q;
	logic [rovl_pkg::ODIM_W-1:0] overlay_height_q;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [AW-1:0]    load_addr_q;

	logic [CW-1:0]    fw_c, fh_c, ow_c, oh_c, cw_c, ch_c;
	logic [CNT_W-1:0] col_c, row_c;
	logic [CW-1:0]    col_e, row_e, ovx_e, ovy_e, dx_c, dy_c;
	logic             in_x, in_y, last_col, last_row;
	logic [AW-1:0]    la_c, la_next;
	logic             s1_adv, acc;

	logic             v_s1;
	logic             is_frame_s1;
	logic             inside_s1;
	logic             frame_end_s1;
	logic [rovl_pkg::CHAN_W-1:0] red_s1, green_s1, blue_s1, alpha_s1;
	logic [AW-1:0]    la_s1;
	logic [OXW-1:0]   ox_s1;
	logic [OYW-1:0]   oy_s1;
	logic [OWM-1:0]   ow_m;
	logic [PW-1:0]    prod;

	// Clamp the frame and overlay sizes to the supported range.
	always_comb begin
		if (frame_width_q == '0) begin
			fw_c = CW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_FD)) begin
			fw_c = CW'(MAX_FD);
		end else begin
			fw_c = CW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			fh_c = CW'(1);
		end else if (32'(frame_height_q) > 32'(MAX_FD)) begin
			fh_c = CW'(MAX_FD);
		end else begin
			fh_c = CW'(frame_height_q);
		end
		ow_c = (32'(overlay_width_q) > 32'(MAX_OW)) ? CW'(MAX_OW) : CW'(overlay_width_q);
		oh_c = (32'(overlay_height_q) > 32'(MAX_OH)) ? CW'(MAX_OH) : CW'(overlay_height_q);
		cw_c = (ow_c < fw_c) ? ow_c : fw_c;
		ch_c = (oh_c < fh_c) ? oh_c : fh_c;
	end

	// Locate the pixel and test it against the visible overlay window.
	always_comb begin
		col_c    = first ? '0 : col_q;
		row_c    = first ? '0 : row_q;
		col_e    = CW'(col_c);
		row_e    = CW'(row_c);
		ovx_e    = CW'(overlay_x_q);
		ovy_e    = CW'(overlay_y_q);
		dx_c     = col_e - ovx_e;
		dy_c     = row_e - ovy_e;
		in_x     = (col_e >= ovx_e) && (dx_c < cw_c);
		in_y     = (row_e >= ovy_e) && (dy_c < ch_c);
		last_col = (col_e + CW'(1)) >= fw_c;
		last_row = (row_e + CW'(1)) >= fh_c;
		la_c     = first ? '0 : load_addr_q;
		la_next  = (la_c == AW'(DEPTH-1)) ? '0 : la_c + AW'(1);
	end

	assign s1_adv    = !v_s1 || !q_full;
	assign full      = !s1_adv;
	assign acc       = push && s1_adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= rovl_pkg::FDIM_W'(640);
			frame_height_q   <= rovl_pkg::FDIM_W'(480);
			overlay_x_q      <= '0;
			overlay_y_q      <= '0;
			overlay_width_q  <= '0;
			overlay_height_q <= '0;
			col_q            <= '0;
			row_q            <= '0;
			load_addr_q      <= '0;
			v_s1             <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (rovl_pkg::cfg_reg_e'(cfg_index))
					rovl_pkg::REG_FRAME_WIDTH: begin
						frame_width_q <= cfg_data[rovl_pkg::FDIM_W-1:0];
					end
					rovl_pkg::REG_FRAME_HEIGHT: begin
						frame_height_q <= cfg_data[rovl_pkg::FDIM_W-1:0];
					end
					rovl_pkg::REG_OVERLAY_X: begin
						overlay_x_q <= cfg_data[rovl_pkg::OFS_W-1:0];
					end
					rovl_pkg::REG_OVERLAY_Y: begin
						overlay_y_q <= cfg_data[rovl_pkg::OFS_W-1:0];
					end
					rovl_pkg::REG_OVERLAY_WIDTH: begin
						overlay_width_q <= cfg_data[rovl_pkg::ODIM_W-1:0];
					end
					rovl_pkg::REG_OVERLAY_HEIGHT: begin
						overlay_height_q <= cfg_data[rovl_pkg::ODIM_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (acc && cmd == rovl_pkg::CMD_FRAME) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : CNT_W'(row_e + CW'(1));
				end else begin
					col_q <= CNT_W'(col_e + CW'(1));
					row_q <= row_c;
				end
			end
			if (acc && cmd == rovl_pkg::CMD_LOAD) begin
				load_addr_q <= la_next;
			end
			if (s1_adv) begin
				v_s1 <= push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			is_frame_s1  <= (cmd == rovl_pkg::CMD_FRAME);
			inside_s1    <= in_x && in_y;
			frame_end_s1 <= last_col && last_row;
			red_s1       <= red;
			green_s1     <= green;
			blue_s1      <= blue;
			alpha_s1     <= alpha;
			la_s1        <= la_c;
			ox_s1        <= OXW'(dx_c);
			oy_s1        <= OYW'(dy_c);
		end
	end

	// Row-major store address of the overlay pixel for frame items; load items use the load address.
	assign ow_m = OWM'(ow_c);
	assign prod = PW'(oy_s1) * PW'(ow_m);

	assign q_push           = v_s1 && !q_full;
	assign q_addr           = is_frame_s1 ? AW'(prod) + AW'(ox_s1) : la_s1;
	assign q_item.is_frame  = is_frame_s1;
	assign q_item.in_window = inside_s1;
	assign q_item.frame_end = frame_end_s1;
	assign q_item.red       = red_s1;
	assign q_item.green     = green_s1;
	assign q_item.blue      = blue_s1;
	assign q_item.alpha     = alpha_s1;

	`ROVL_ASSERT_NXT(a_s1_hold, clk, arst_n, v_s1 && q_full, v_s1, "front stage dropped a stalled item")

endmodule

// ===== rtl/core/rovl_back.sv =====
// Back end: overlay store access and per-channel alpha blend.
`include "rgba_overlay_alpha_blend_top_macros.svh"

module rovl_back #(
	parameter int DEPTH     = rovl_pkg::MAX_OVERLAY_WIDTH_DEF * rovl_pkg::MAX_OVERLAY_HEIGHT_DEF,
	parameter int OUT_DEPTH = rovl_pkg::OUT_Q_DEPTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_empty,
	input  logic [rovl_pkg::addr_bits(DEPTH)-1:0] in_addr,
	input  rovl_pkg::q_item_t                     in_item,
	output logic                                  in_pop,
	input  logic                                  out_full,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]        out_count,
	output logic                                  out_push,
	output rovl_pkg::out_item_t                   out_item
);

	localparam int AW  = rovl_pkg::addr_bits(DEPTH);
	localparam int OCW = $clog2(OUT_DEPTH+1) + 1;
	localparam int CH  = rovl_pkg::CHAN_W;

	logic [OCW-1:0]    pend;
	logic              credit_ok;
	logic              ram_we, ram_re;
	logic [4*CH-1:0]   ram_wdata, ram_rdata;

	logic              v_s1;
	rovl_pkg::q_item_t meta_s1;
	logic              v_s2;
	rovl_pkg::out_item_t res_s2;
	rovl_pkg::out_item_t res_c;
	logic [CH-1:0]     wa;

	function automatic logic [CH-1:0] mix(input logic [CH-1:0] ov, input logic [CH-1:0] a,
			input logic [CH-1:0] pix);
		logic [2*CH-1:0] s;
		s = (2*CH)'(ov) * (2*CH)'(a) + (2*CH)'(pix) * (2*CH)'(8'd255 - a);
		return s[2*CH-1:CH];
	endfunction

	// Count results already owed to the output queue before taking a frame item.
	assign pend      = OCW'(out_count) + OCW'(v_s1) + OCW'(v_s2);
	assign credit_ok = pend < OCW'(OUT_DEPTH);
	assign in_pop    = !in_empty && (!in_item.is_frame || credit_ok);
	assign ram_we    = in_pop && !in_item.is_frame;
	assign ram_re    = in_pop && in_item.is_frame;
	assign ram_wdata = {in_item.alpha, in_item.blue, in_item.green, in_item.red};

	rovl_ram #(
		.WIDTH(4*CH),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		wa                = ram_rdata[4*CH-1:3*CH];
		res_c.blended     = meta_s1.in_window;
		res_c.frame_end   = meta_s1.frame_end;
		if (meta_s1.in_window) begin
			res_c.red   = mix(ram_rdata[CH-1:0], wa, meta_s1.red);
			res_c.green = mix(ram_rdata[2*CH-1:CH], wa, meta_s1.green);
			res_c.blue  = mix(ram_rdata[3*CH-1:2*CH], wa, meta_s1.blue);
		end else begin
			res_c.red   = meta_s1.red;
			res_c.green = meta_s1.green;
			res_c.blue  = meta_s1.blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ram_re;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			meta_s1 <= in_item;
		end
		if (v_s1) begin
			res_s2 <= res_c;
		end
	end

	assign out_push = v_s2;
	assign out_item = res_s2;

	`ROVL_ASSERT_NXT(a_s1_to_s2, clk, arst_n, v_s1, v_s2, "blend stage lost an item")
	`ROVL_ASSERT_NOW(a_out_room, clk, arst_n, v_s2, !out_full, "result pushed into full queue")
	`ROVL_ASSERT_NOW(a_pop_ok, clk, arst_n, in_pop, !in_empty && !(ram_we && ram_re), "bad pop")

endmodule
